[hw/rtl/mstw_pkg.sv]
// mstw_pkg: shared constants and types for the spanning tree weight block.
// No dependencies; used by mstw_prim and prim_mst_total_weight.
package mstw_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 32;

  localparam int VERTEX_W    = 6;
  localparam int WEIGHT_IN_W = 32;
  localparam int VCOUNT_W    = 7;
  localparam int SUM_W       = 38;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] total;
    logic             connected;
  } prim_res_t;

endpackage

[hw/rtl/mstw_ram.sv]
// mstw_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module mstw_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/mstw_prim.sv]
// mstw_prim: Prim sequencer; key memory, tree flags, one row pass per added vertex.
// Depends on mstw_pkg and mstw_ram; reads the edge memory through the top level.
module mstw_prim #(
  parameter int MaxVertices = mstw_pkg::MAX_VERTICES_DEF,
  parameter int WeightBits  = mstw_pkg::WEIGHT_BITS_DEF,
  localparam int VW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1,
  localparam int CW = $clog2(MaxVertices + 1),
  localparam int EW = WeightBits + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CW-1:0]       n_i,
  output logic [2*VW-1:0]     edge_raddr_o,
  input  logic [EW-1:0]       edge_rdata_i,
  output mstw_pkg::prim_res_t res_o
);

  localparam int DW = EW + 1;
  localparam logic [EW-1:0] Inf = {1'b1, {WeightBits{1'b0}}};
  localparam logic [63:0] SumMax = 64'((64'd1 << mstw_pkg::SUM_W) - 64'd1);

  typedef enum logic [3:0] {
    P_IDLE  = 4'b0001,
    P_SCAN  = 4'b0010,
    P_DRAIN = 4'b0100,
    P_NEXT  = 4'b1000
  } pstate_e;

  pstate_e                     state_q;
  logic [VW-1:0]               u_q;
  logic [CW-1:0]               j_q;
  logic [CW-1:0]               added_q;
  logic                        first_q;
  logic [mstw_pkg::SUM_W-1:0]  sum_q;
  logic [EW-1:0]               best_q;
  logic [VW-1:0]               best_idx_q;
  logic                        found_q;
  logic                        v2_q;
  logic [VW-1:0]               j2_q;
  mstw_pkg::prim_res_t         res_q;

  // key memory entry: [EW] in tree, [EW-1:0] key
  logic [DW-1:0]               dist_rdata;
  logic                        tree_old;
  logic [EW-1:0]               d_old;
  logic [EW-1:0]               d_new;
  logic                        upd;
  logic                        dist_we;
  logic [VW-1:0]               dist_waddr;
  logic [DW-1:0]               dist_wdata;
  logic [63:0]                 sum_wide;
  logic [mstw_pkg::SUM_W-1:0]  sum_new;
  logic                        last_j;

  always_comb begin
    tree_old = first_q ? (j2_q == '0) : dist_rdata[EW];
    d_old    = first_q ? Inf : dist_rdata[EW-1:0];
    d_new    = (edge_rdata_i < d_old) ? edge_rdata_i : d_old;
    upd      = v2_q && !tree_old;
    sum_wide = 64'(sum_q) + 64'(best_q);
    sum_new  = (sum_wide > SumMax) ? mstw_pkg::SUM_W'(SumMax)
                                   : mstw_pkg::SUM_W'(sum_wide);
    last_j   = (CW'(j_q + 1'b1) == n_i);
    if (state_q == P_NEXT) begin
      dist_we    = found_q;
      dist_waddr = best_idx_q;
      dist_wdata = {1'b1, best_q};
    end else begin
      dist_we    = v2_q && (first_q || !tree_old);
      dist_waddr = j2_q;
      dist_wdata = {tree_old, d_new};
    end
  end

  assign edge_raddr_o = {u_q, j_q[VW-1:0]};
  assign res_o        = res_q;

  mstw_ram #(
    .Width(DW),
    .Depth(MaxVertices)
  ) u_dist_ram (
    .clk_i  (clk_i),
    .we_i   (dist_we),
    .waddr_i(dist_waddr),
    .wdata_i(dist_wdata),
    .raddr_i(j_q[VW-1:0]),
    .rdata_o(dist_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= P_IDLE;
      u_q        <= '0;
      j_q        <= '0;
      added_q    <= '0;
      first_q    <= 1'b0;
      sum_q      <= '0;
      best_q     <= Inf;
      best_idx_q <= '0;
      found_q    <= 1'b0;
      v2_q       <= 1'b0;
      j2_q       <= '0;
      res_q      <= '0;
    end else begin
      if (state_q != P_NEXT) begin
        res_q.done <= 1'b0;
      end
      if (upd && (d_new < best_q)) begin
        best_q     <= d_new;
        best_idx_q <= j2_q;
        found_q    <= 1'b1;
      end
      case (state_q)
        P_IDLE: begin
          v2_q <= 1'b0;
          if (start_i) begin
            u_q       <= '0;
            j_q       <= '0;
            added_q   <= CW'(1);
            first_q   <= 1'b1;
            sum_q     <= '0;
            best_q    <= Inf;
            found_q   <= 1'b0;
            state_q   <= P_SCAN;
          end
        end
        P_SCAN: begin
          v2_q <= 1'b1;
          j2_q <= j_q[VW-1:0];
          j_q  <= CW'(j_q + 1'b1);
          if (last_j) begin
            state_q <= P_DRAIN;
          end
        end
        P_DRAIN: begin
          v2_q    <= 1'b0;
          state_q <= P_NEXT;
        end
        P_NEXT: begin
          if (found_q) begin
            sum_q                 <= sum_new;
            added_q               <= CW'(added_q + 1'b1);
            u_q                   <= best_idx_q;
            first_q               <= 1'b0;
            j_q                   <= '0;
            best_q                <= Inf;
            found_q               <= 1'b0;
            if (CW'(added_q + 1'b1) == n_i) begin
              res_q.done      <= 1'b1;
              res_q.total     <= sum_new;
              res_q.connected <= 1'b1;
              state_q         <= P_IDLE;
            end else begin
              state_q <= P_SCAN;
            end
          end else begin
            res_q.done      <= 1'b1;
            res_q.total     <= sum_q;
            res_q.connected <= (added_q == n_i);
            state_q         <= P_IDLE;
          end
        end
        default: begin
          state_q <= P_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/prim_mst_total_weight.sv]
// prim_mst_total_weight: top level; edge matrix memory, load stage, clear sweep, control.
// Depends on mstw_pkg, mstw_ram and mstw_prim.
//
//  channel  | direction | handshake                    | payload
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata, tuser, tlast
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata, tuser
//  cfg      | in        | cfg_valid_i / cfg_ready_o    | cfg_data_i (vertex count)
//
// Edge requests load one per cycle (read-modify-write of the matrix, forwarded).
// After the last request the block passes a flush state, then Prim makes one row pass per
// added vertex, and the result is registered to the output.
// The matrix is then swept back to no-edge, one entry per cycle over all 2^(2*clog2(MaxVertices))
// entries (4096 by default), also right after reset; no request is taken meanwhile.
// A pending result waits for m_axis_tready; the next result waits on it.
module prim_mst_total_weight #(
  parameter int MaxVertices = mstw_pkg::MAX_VERTICES_DEF,
  parameter int WeightBits  = mstw_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [5:0] from_vertex, [11:6] to_vertex, [43:12] weight, [47:44] zero
  input  logic [mstw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] edge_present
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [37:0] total_weight, [39:38] zero
  output logic [mstw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [0] connected
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mstw_pkg::VCOUNT_W-1:0]       cfg_data_i
);

  localparam int VW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CW = $clog2(MaxVertices + 1);
  localparam int EW = WeightBits + 1;
  localparam int AW = 2 * VW;
  localparam logic [EW-1:0] Inf = {1'b1, {WeightBits{1'b0}}};
  localparam int NReset = (int'(mstw_pkg::VCOUNT_RESET) > MaxVertices)
                          ? MaxVertices : int'(mstw_pkg::VCOUNT_RESET);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_FLUSH  = 5'b00100,
    ST_PRIM   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_q;
  logic [CW-1:0]       n_q;
  logic                ld_v_q;
  logic [AW-1:0]       ld_addr_q;
  logic [EW-1:0]       ld_w_q;
  logic                fwd_v_q;
  logic [AW-1:0]       fwd_addr_q;
  logic [EW-1:0]       fwd_w_q;
  logic                m_valid_q;

  logic [mstw_pkg::VERTEX_W-1:0]    in_from;
  logic [mstw_pkg::VERTEX_W-1:0]    in_to;
  logic [mstw_pkg::WEIGHT_IN_W-1:0] in_weight;
  logic                             in_accept;
  logic                             in_range;
  logic [AW-1:0]                    in_addr;

  logic [EW-1:0]       edge_rdata;
  logic [EW-1:0]       ld_old;
  logic                ld_we;
  logic                edge_we;
  logic [AW-1:0]       edge_waddr;
  logic [EW-1:0]       edge_wdata;
  logic [AW-1:0]       edge_raddr;
  logic [AW-1:0]       prim_raddr;
  logic                prim_start;
  mstw_pkg::prim_res_t prim_res;
  logic                out_load;

  assign in_from   = s_axis_tdata[5:0];
  assign in_to     = s_axis_tdata[11:6];
  assign in_weight = s_axis_tdata[43:12];

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_range      = (int'(in_from) < MaxVertices) && (int'(in_to) < MaxVertices);
  assign in_addr       = {VW'(in_from), VW'(in_to)};
  assign cfg_ready_o   = 1'b1;
  assign prim_start    = (state_q == ST_FLUSH);
  assign out_load      = (state_q == ST_FINISH) && (!m_valid_q || m_axis_tready);

  always_comb begin
    ld_old = (fwd_v_q && (fwd_addr_q == ld_addr_q)) ? fwd_w_q : edge_rdata;
    ld_we  = ld_v_q && (ld_w_q < ld_old);
    if (state_q == ST_CLEAR) begin
      edge_we    = 1'b1;
      edge_waddr = clr_q;
      edge_wdata = Inf;
    end else begin
      edge_we    = ld_we;
      edge_waddr = ld_addr_q;
      edge_wdata = ld_w_q;
    end
    edge_raddr = (state_q == ST_LOAD) ? in_addr : prim_raddr;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (&clr_q) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (in_accept && s_axis_tlast) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_PRIM;
      end
      ST_PRIM: begin
        if (prim_res.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_CLEAR;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  mstw_ram #(
    .Width(EW),
    .Depth(1 << AW)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (edge_we),
    .waddr_i(edge_waddr),
    .wdata_i(edge_wdata),
    .raddr_i(edge_raddr),
    .rdata_o(edge_rdata)
  );

  mstw_prim #(
    .MaxVertices(MaxVertices),
    .WeightBits (WeightBits)
  ) u_prim (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (prim_start),
    .n_i         (n_q),
    .edge_raddr_o(prim_raddr),
    .edge_rdata_i(edge_rdata),
    .res_o       (prim_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      n_q       <= CW'(NReset);
      ld_v_q    <= 1'b0;
      fwd_v_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= AW'(clr_q + 1'b1);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_data_i == '0) begin
          n_q <= CW'(1);
        end else if (int'(cfg_data_i) > MaxVertices) begin
          n_q <= CW'(MaxVertices);
        end else begin
          n_q <= CW'(cfg_data_i);
        end
      end
      ld_v_q  <= in_accept && s_axis_tuser && in_range;
      fwd_v_q <= ld_we;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ld_addr_q  <= in_addr;
    ld_w_q     <= {1'b0, WeightBits'(in_weight)};
    fwd_addr_q <= ld_addr_q;
    fwd_w_q    <= ld_w_q;
    if (out_load) begin
      m_axis_tdata <= mstw_pkg::OUT_TDATA_W'(prim_res.total);
      m_axis_tuser <= prim_res.connected;
    end
  end

  assign m_axis_tvalid = m_valid_q;

`ifndef SYNTHESIS
  a_prim_done_in_prim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    prim_res.done |-> (state_q == ST_PRIM))
    else $error("prim result outside of compute phase");

  a_no_load_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !ld_v_q)
    else $error("edge load overlaps clear sweep");

  a_result_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside finish");

  a_start_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    prim_start |-> $past(in_accept && s_axis_tlast))
    else $error("compute started without a last request");
`endif

endmodule
